FILE: rtl/core/dla_pkg.sv
package dla_pkg;

  // Capacity of the operation store, one cell per entry.
  localparam int unsigned MaxOps = 64;

  // Fixed field widths.
  localparam int unsigned TensW = 8;
  localparam int unsigned LvlW  = 6;
  localparam int unsigned IdxW  = 6;

  // Stored-op count, 0 .. MaxOps inclusive.
  localparam int unsigned CntW = $clog2(MaxOps + 1);

  localparam logic [LvlW-1:0] LevelTop = {LvlW{1'b1}};
  localparam logic [IdxW-1:0] IdxFull  = {IdxW{1'b1}};

  // Query travelling down the cell chain.
  typedef struct packed {
    logic             valid;
    logic             has_b;
    logic [TensW-1:0] read_a;
    logic [TensW-1:0] read_b;
    logic [TensW-1:0] write_t;
    logic [LvlW-1:0]  acc;     // running level of this op
    logic [CntW-1:0]  rem;     // stored entries still to compare
    logic             stored;  // op written into its cell
  } token_t;

  typedef struct packed {
    logic [LvlW-1:0] level;
    logic [LvlW-1:0] peak_level;
    logic [IdxW-1:0] op_index;
    logic            overflow;
  } result_t;

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_WALK = 3'b010,
    S_HOLD = 3'b100
  } state_e;

endpackage

FILE: rtl/core/dla_if.sv
interface dla_op_if;
  logic                      valid;
  logic                      ready;
  logic                      op;
  logic [dla_pkg::TensW-1:0] read_a;
  logic [dla_pkg::TensW-1:0] read_b;
  logic [dla_pkg::TensW-1:0] write_t;
  logic                      first;

  modport source (output valid, output op, output read_a, output read_b,
                  output write_t, output first, input ready);
  modport sink (input valid, input op, input read_a, input read_b,
                input write_t, input first, output ready);
endinterface

interface dla_res_if;
  logic                     valid;
  logic                     ready;
  logic [dla_pkg::LvlW-1:0] level;
  logic [dla_pkg::LvlW-1:0] peak_level;
  logic [dla_pkg::IdxW-1:0] op_index;
  logic                     overflow;

  modport source (output valid, output level, output peak_level, output op_index,
                  output overflow, input ready);
  modport sink (input valid, input level, input peak_level, input op_index,
                input overflow, output ready);
endinterface

FILE: rtl/core/dla_cell.sv
module dla_cell (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  dla_pkg::token_t tok_i,
  output dla_pkg::token_t tok_o
);

  // Stored operation, undefined until written.
  logic [dla_pkg::TensW-1:0] ent_ra_q;
  logic [dla_pkg::TensW-1:0] ent_rb_q;
  logic                      ent_hb_q;
  logic [dla_pkg::TensW-1:0] ent_wr_q;
  logic [dla_pkg::LvlW-1:0]  ent_lvl_q;

  dla_pkg::token_t          tok_d;
  dla_pkg::token_t          tok_q;
  logic                     hit;
  logic                     wr_en;
  logic [dla_pkg::LvlW-1:0] cand;

  assign hit = (tok_i.read_a == ent_wr_q) ||
               (tok_i.has_b && (tok_i.read_b == ent_wr_q)) ||
               (ent_ra_q == tok_i.write_t) ||
               (ent_hb_q && (ent_rb_q == tok_i.write_t));

  assign cand = (ent_lvl_q == dla_pkg::LevelTop) ? dla_pkg::LevelTop
                                                 : ent_lvl_q + 1'b1;

  always_comb begin
    tok_d = tok_i;
    wr_en = 1'b0;
    if (tok_i.valid) begin
      if (tok_i.rem != '0) begin
        tok_d.rem = tok_i.rem - 1'b1;
        if (hit && (cand > tok_i.acc)) begin
          tok_d.acc = cand;
        end
      end else if (!tok_i.stored) begin
        // first free entry: the op lands here
        tok_d.stored = 1'b1;
        wr_en        = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tok_q <= '0;
    end else begin
      tok_q <= tok_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      ent_ra_q  <= tok_i.read_a;
      ent_rb_q  <= tok_i.has_b ? tok_i.read_b : '0;
      ent_hb_q  <= tok_i.has_b;
      ent_wr_q  <= tok_i.write_t;
      ent_lvl_q <= tok_i.acc;
    end
  end

  assign tok_o = tok_q;

endmodule

FILE: rtl/core/dependency_level_assigner.sv
// Each accepted operation is registered into the launch slot, walks the whole chain of MaxOps
// cells, one cell per cycle, and its result is registered at the output; a new one is taken
// only once the last result is registered.
// Reset clears the op count, running maximum and all handshake state; stored entries stay
// undefined and are never read before being written, so no clearing pass is needed.
module dependency_level_assigner (
  input  logic            clk_i,
  input  logic            rst_ni,
  dla_op_if.sink          op_i,
  dla_res_if.source       res_o
);

  dla_pkg::state_e  state_q, state_d;
  dla_pkg::token_t  launch_q, launch_d;
  dla_pkg::token_t  chain [dla_pkg::MaxOps+1];
  dla_pkg::token_t  end_tok;
  dla_pkg::result_t res_d, res_q, hold_d, hold_q, out_d, out_q;
  logic             out_valid_q, out_valid_d;
  logic [dla_pkg::CntW-1:0] count_q, count_d;
  logic [dla_pkg::LvlW-1:0] rmax_q, rmax_d;
  logic [dla_pkg::LvlW-1:0] new_max;
  logic             in_acc;
  logic             out_free;

  assign chain[0] = launch_q;

  for (genvar g = 0; g < dla_pkg::MaxOps; g++) begin : g_cell
    dla_cell u_cell (
      .clk_i (clk_i),
      .rst_ni(rst_ni),
      .tok_i (chain[g]),
      .tok_o (chain[g+1])
    );
  end

  assign end_tok  = chain[dla_pkg::MaxOps];
  assign op_i.ready = (state_q == dla_pkg::S_IDLE);
  assign in_acc   = op_i.valid && op_i.ready;
  assign out_free = !out_valid_q || res_o.ready;

  assign new_max = (end_tok.acc > rmax_q) ? end_tok.acc : rmax_q;

  always_comb begin
    res_d.level      = end_tok.acc;
    res_d.overflow   = !end_tok.stored;
    res_d.peak_level = end_tok.stored ? new_max : rmax_q;
    res_d.op_index   = end_tok.stored ? dla_pkg::IdxW'(count_q) : dla_pkg::IdxFull;
  end

  always_comb begin
    state_d     = state_q;
    launch_d    = launch_q;
    hold_d      = hold_q;
    out_d       = out_q;
    count_d     = count_q;
    rmax_d      = rmax_q;
    out_valid_d = out_valid_q && !res_o.ready;

    launch_d.valid = 1'b0;

    unique case (state_q)
      dla_pkg::S_IDLE: begin
        if (in_acc) begin
          launch_d.valid   = 1'b1;
          launch_d.has_b   = op_i.op;
          launch_d.read_a  = op_i.read_a;
          launch_d.read_b  = op_i.read_b;
          launch_d.write_t = op_i.write_t;
          launch_d.acc     = '0;
          launch_d.rem     = op_i.first ? '0 : count_q;
          launch_d.stored  = 1'b0;
          if (op_i.first) begin
            count_d = '0;
            rmax_d  = '0;
          end
          state_d = dla_pkg::S_WALK;
        end
      end
      dla_pkg::S_WALK: begin
        if (end_tok.valid) begin
          if (end_tok.stored) begin
            count_d = count_q + 1'b1;
            rmax_d  = new_max;
          end
          if (out_free) begin
            out_d       = res_d;
            out_valid_d = 1'b1;
            state_d     = dla_pkg::S_IDLE;
          end else begin
            hold_d  = res_d;
            state_d = dla_pkg::S_HOLD;
          end
        end
      end
      dla_pkg::S_HOLD: begin
        if (out_free) begin
          out_d       = hold_q;
          out_valid_d = 1'b1;
          state_d     = dla_pkg::S_IDLE;
        end
      end
      default: begin
        state_d = dla_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= dla_pkg::S_IDLE;
      launch_q    <= '0;
      out_valid_q <= 1'b0;
      count_q     <= '0;
      rmax_q      <= '0;
    end else begin
      state_q     <= state_d;
      launch_q    <= launch_d;
      out_valid_q <= out_valid_d;
      count_q     <= count_d;
      rmax_q      <= rmax_d;
    end
  end

  always_ff @(posedge clk_i) begin
    hold_q <= hold_d;
    out_q  <= out_d;
  end

  assign res_q            = out_q;
  assign res_o.valid      = out_valid_q;
  assign res_o.level      = res_q.level;
  assign res_o.peak_level = res_q.peak_level;
  assign res_o.op_index   = res_q.op_index;
  assign res_o.overflow   = res_q.overflow;

`ifndef ASSERT_OFF
  // a query only reaches the chain end while the walk is in progress
  a_end_in_walk: assert property (@(posedge clk_i) disable iff (!rst_ni)
    end_tok.valid |-> (state_q == dla_pkg::S_WALK))
    else $error("query left the chain outside a walk");

  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= dla_pkg::CntW'(dla_pkg::MaxOps))
    else $error("op count beyond capacity");

  // launch pulses exactly once, right after an accepted transaction
  a_launch_once: assert property (@(posedge clk_i) disable iff (!rst_ni)
    launch_q.valid |-> $past(in_acc))
    else $error("launch without accepted transaction");

  a_max_covers_level: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_o.valid && !res_o.overflow) |-> (res_o.peak_level >= res_o.level))
    else $error("peak_level below level of stored op");
`endif

endmodule
